// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/sss_pkg.sv -----
// Package with the constants and types of the sorted set statistics block.
`timescale 1ns / 1ps
package sss_pkg;
   localparam int DEFAULT_DEPTH = 16;
   localparam int SAMPLE_W = 32;
   localparam int RESULT_W = 40;
   localparam int KIND_W = 3;
   localparam int SUM_W = 37;
   localparam int MEAN_W = 46;
   localparam logic [KIND_W-1:0] KIND_SORTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MAX = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MIN = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MEAN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MEDIAN = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MODE = 3'd5;
   typedef enum logic [3:0] {
      ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_EMIT_RD, ST_EMIT, ST_STATS, ST_DIV,
      ST_MED_RD, ST_MED, ST_MODE_RD, ST_MODE, ST_CLEAR
   } state_type;
   // Status that the divider returns to the controller.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;
endpackage

// ----- hw/rtl/sss_divider.sv -----
// Restoring divider for the signed mean, one quotient bit per cycle.
`timescale 1ns / 1ps
module sss_divider
   import sss_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [CNT_W-1:0]         divisor,
   output div_status_type           status,
   output logic signed [MEAN_W-1:0] quotient
);
   localparam int STEP_W = $clog2(MEAN_W + 1);
   logic [MEAN_W-1:0] num_ff, num_in;
   logic [CNT_W:0] rem_ff, rem_in;
   logic [CNT_W-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [MEAN_W-1:0] mag;
   logic [CNT_W:0] trial;

   always_comb begin
      mag = '0;
      trial = {rem_ff[CNT_W-1:0], num_ff[MEAN_W-1]};
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         mag = dividend[SUM_W-1] ? MEAN_W'(-{{(MEAN_W-SUM_W){dividend[SUM_W-1]}}, dividend})
                                 : MEAN_W'(dividend);
         num_in = mag << 8;
         rem_in = '0; den_in = divisor; neg_in = dividend[SUM_W-1];
         step_in = STEP_W'(MEAN_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[MEAN_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[MEAN_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
      if (reset) begin
         step_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         step_ff <= step_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign quotient = neg_ff ? -$signed(num_ff) : $signed(num_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

// ----- hw/rtl/sss_store.sv -----
// Element memory: one write port and one registered read port.
`timescale 1ns / 1ps
module sss_store
   import sss_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);
   logic signed [SAMPLE_W-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hw/rtl/sorted_set_statistics.sv -----
// Top level of the sorted set statistics block.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Samples are taken one beat per cycle into a memory of STORE_DEPTH entries; the
// beat with req_final_item closes the set. The block then sorts the memory in place
// by insertion sort through its single read and single write port. For each element it
// reads the key, then reads and compares the elements before it, shifting each larger
// one up by one address, and writes the key into the gap. It then emits the N sorted
// values, the largest, the smallest, the mean (8 fraction bits, from a bit-serial
// divider that is started when the smallest is loaded), the median, and every most
// frequent value once, ascending. The mode search scans the sorted memory twice, one
// pass to find the longest run and count how many runs reach it, one pass to emit
// them; a final state clears the set. Each result beat waits until the previous one
// has been taken with rsp_ready. No new sample is accepted until the last result of
// the set has been taken. Samples beyond the depth are dropped and rsp_overflowed is
// set on every result of that set.
module sorted_set_statistics
   import sss_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_final_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [KIND_W-1:0]          rsp_kind,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic                       rsp_end_of_run,
   output logic                       rsp_overflowed
);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] run_ff, run_in, best_ff, best_in;
   logic [CNT_W-1:0] mcnt_ff, mcnt_in;  // number of runs that reach the longest length
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic drop_ff, drop_in;
   logic signed [SAMPLE_W-1:0] key_ff, key_in, prev_ff, prev_in, lo_ff, lo_in;
   logic pass_ff, pass_in;         // mode: first pass finds best, second emits
   logic [2:0] sub_ff, sub_in;     // step within ST_SORT_CMP / ST_STATS / ST_DIV / ST_MED
   logic out_v_ff, out_v_in, out_e_ff, out_e_in;
   logic [KIND_W-1:0] out_k_ff, out_k_in;
   logic signed [RESULT_W-1:0] out_d_ff, out_d_in;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic signed [SAMPLE_W-1:0] wr_data, rd_data;
   logic div_start;
   div_status_type div_st;
   logic signed [MEAN_W-1:0] quot;
   logic out_free, acc;
   logic signed [SAMPLE_W:0] msum, mround;
   logic mode_end, mode_stall;

   sss_store #(.DEPTH(STORE_DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   sss_divider #(.CNT_W(CNT_W)) u_div (
      .clock, .reset, .start(div_start), .dividend(total_ff),
      .divisor(count_ff), .status(div_st), .quotient(quot));

   assign out_free = !out_v_ff || rsp_ready;
   assign req_ready = (state_ff == ST_LOAD) && !out_v_ff;
   assign acc = req_valid && req_ready;
   assign msum = {rd_data[SAMPLE_W-1], rd_data} + {lo_ff[SAMPLE_W-1], lo_ff};
   // Adding one to a negative sum makes the halving truncate toward zero.
   assign mround = msum + $signed({{SAMPLE_W{1'b0}}, msum[SAMPLE_W]});

   // A run of equal values ends when the element differs or the scan reaches the count.
   assign mode_end = (i_ff != '0) && (i_ff == count_ff || rd_data != prev_ff);
   // In the emitting pass a finished longest run waits for room in the output register.
   assign mode_stall = pass_ff && mode_end && run_ff == best_ff && !out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (acc && req_final_item) state_in = ST_SORT_RD;
         ST_SORT_RD: state_in = (i_ff >= count_ff) ? ST_EMIT_RD : ST_SORT_CMP;
         ST_SORT_CMP:
            if (sub_ff == 3'd2 && !(j_ff != '0 && rd_data > key_ff)) state_in = ST_SORT_RD;
         ST_EMIT_RD: state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = (i_ff + 1'b1 == count_ff) ? ST_STATS : ST_EMIT_RD;
         ST_STATS: if (out_free && sub_ff == 3'd2) state_in = ST_DIV;
         ST_DIV: if (sub_ff == 3'd3 && out_free) state_in = ST_MED_RD;
         ST_MED_RD: state_in = ST_MED;
         ST_MED: if (sub_ff != 3'd0 && out_free) state_in = ST_MODE_RD;
         ST_MODE_RD: state_in = ST_MODE;
         ST_MODE:
            if (!mode_stall) state_in = (pass_ff && i_ff == count_ff) ? ST_CLEAR : ST_MODE_RD;
         ST_CLEAR: if (out_free) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in = count_ff; i_in = i_ff; j_in = j_ff; run_in = run_ff;
      best_in = best_ff; mcnt_in = mcnt_ff; total_in = total_ff; drop_in = drop_ff;
      key_in = key_ff; prev_in = prev_ff; lo_in = lo_ff; pass_in = pass_ff;
      sub_in = sub_ff;
      out_v_in = out_v_ff && !rsp_ready; out_e_in = out_e_ff;
      out_k_in = out_k_ff; out_d_in = out_d_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = key_ff; rd_addr = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            wr_addr = count_ff[ADDR_W-1:0]; wr_data = req_sample;
            if (acc) begin
               if (count_ff < CNT_W'(STORE_DEPTH)) begin
                  wr_en = 1'b1; count_in = count_ff + 1'b1;
                  total_in = total_ff + SUM_W'(req_sample);
               end else begin
                  drop_in = 1'b1;
               end
               i_in = CNT_W'(1);
            end
         end
         ST_SORT_RD: begin
            rd_addr = i_ff[ADDR_W-1:0];
            j_in = i_ff; sub_in = 3'd0;
            // The sort is done; the emit scan starts from the first element.
            if (i_ff >= count_ff) i_in = '0;
         end
         ST_SORT_CMP: begin
            // sub 0: rd_data is the key; later: rd_data is element j-1.
            rd_addr = ADDR_W'(j_ff - 1'b1);
            if (sub_ff == 3'd0) begin
               key_in = rd_data; sub_in = 3'd1;
            end else if (sub_ff == 3'd1) begin
               sub_in = 3'd2;    // read of j-1 in flight
            end else if (j_ff != '0 && rd_data > key_ff) begin
               wr_en = 1'b1; wr_addr = j_ff[ADDR_W-1:0]; wr_data = rd_data;
               j_in = j_ff - 1'b1; sub_in = 3'd1;
               rd_addr = ADDR_W'(j_ff - 2'd2);
            end else begin
               wr_en = 1'b1; wr_addr = j_ff[ADDR_W-1:0]; wr_data = key_ff;
               i_in = i_ff + 1'b1;
            end
         end
         ST_EMIT_RD: rd_addr = i_ff[ADDR_W-1:0];
         ST_EMIT: begin
            rd_addr = i_ff[ADDR_W-1:0];
            if (out_free) begin
               out_v_in = 1'b1; out_k_in = KIND_SORTED; out_e_in = 1'b0;
               out_d_in = RESULT_W'(rd_data);
               if (i_ff == '0) lo_in = rd_data;
               prev_in = rd_data;
               i_in = i_ff + 1'b1;
               // Enter ST_STATS with sub 1 so the largest is emitted first.
               if (i_ff + 1'b1 == count_ff) sub_in = 3'd1;
            end
         end
         ST_STATS: begin
            rd_addr = ADDR_W'(count_ff - 1'b1);
            if (out_free && sub_ff == 3'd1) begin
               out_v_in = 1'b1; out_k_in = KIND_MAX; out_d_in = RESULT_W'(prev_ff);
               sub_in = 3'd2;
            end else if (out_free && sub_ff == 3'd2) begin
               out_v_in = 1'b1; out_k_in = KIND_MIN; out_d_in = RESULT_W'(lo_ff);
               div_start = 1'b1; sub_in = 3'd0;
            end
         end
         ST_DIV: begin
            if (div_st.done || (!div_st.busy && sub_ff == 3'd3)) sub_in = 3'd3;
            if (sub_ff == 3'd3 && out_free) begin
               out_v_in = 1'b1; out_k_in = KIND_MEAN; out_d_in = RESULT_W'(quot);
               sub_in = 3'd0;
            end
         end
         ST_MED_RD: begin
            rd_addr = ADDR_W'((count_ff - 1'b1) >> 1);
         end
         ST_MED: begin
            rd_addr = ADDR_W'(count_ff >> 1);
            if (sub_ff == 3'd0) begin
               lo_in = rd_data;
               sub_in = count_ff[0] ? 3'd2 : 3'd1;
            end else if (sub_ff == 3'd1 && out_free) begin
               out_v_in = 1'b1; out_k_in = KIND_MEDIAN;
               out_d_in = RESULT_W'(mround >>> 1);
               sub_in = 3'd0; i_in = '0; run_in = '0; best_in = '0; mcnt_in = '0;
               pass_in = 1'b0;
            end else if (sub_ff == 3'd2 && out_free) begin
               out_v_in = 1'b1; out_k_in = KIND_MEDIAN; out_d_in = RESULT_W'(lo_ff);
               sub_in = 3'd0; i_in = '0; run_in = '0; best_in = '0; mcnt_in = '0;
               pass_in = 1'b0;
            end
         end
         ST_MODE_RD: rd_addr = i_ff[ADDR_W-1:0];
         ST_MODE: begin
            // Element i is in rd_data; prev_ff holds element i-1.
            rd_addr = i_ff[ADDR_W-1:0];
            if (mode_end) begin
               if (!pass_ff) begin
                  if (run_ff > best_ff) begin
                     best_in = run_ff; mcnt_in = CNT_W'(1);
                  end else if (run_ff == best_ff) begin
                     mcnt_in = mcnt_ff + 1'b1;
                  end
               end else if (run_ff == best_ff && out_free) begin
                  // The last of the counted longest runs closes the set.
                  out_v_in = 1'b1; out_k_in = KIND_MODE; out_d_in = RESULT_W'(prev_ff);
                  out_e_in = (mcnt_ff == CNT_W'(1));
                  mcnt_in = mcnt_ff - 1'b1;
               end
               run_in = CNT_W'(1);
            end else begin
               run_in = run_ff + 1'b1;
            end
            if (!mode_stall) begin
               prev_in = rd_data;
               i_in = i_ff + 1'b1;
               if (i_ff == count_ff) begin
                  i_in = '0; run_in = '0; pass_in = 1'b1;
               end
            end else begin
               run_in = run_ff;
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               count_in = '0; total_in = '0; drop_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in; prev_ff <= prev_in; lo_ff <= lo_in;
      out_k_ff <= out_k_in; out_d_ff <= out_d_in;
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; i_ff <= '0; j_ff <= '0; run_ff <= '0;
         best_ff <= '0; mcnt_ff <= '0; total_ff <= '0; drop_ff <= 1'b0; pass_ff <= 1'b0;
         sub_ff <= '0; out_v_ff <= 1'b0; out_e_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; i_ff <= i_in; j_ff <= j_in;
         run_ff <= run_in; best_ff <= best_in; mcnt_ff <= mcnt_in; total_ff <= total_in;
         drop_ff <= drop_in; pass_ff <= pass_in; sub_ff <= sub_in;
         out_v_ff <= out_v_in; out_e_ff <= out_e_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_k_ff;
   assign rsp_result_value = out_d_ff;
   assign rsp_end_of_run = out_e_ff;
   assign rsp_overflowed = drop_ff;

   `ASSERT_IMPL(a_no_load_when_busy, clock, reset, state_ff != ST_LOAD, !req_ready,
                "input accepted while a set is processed")
   `ASSERT_NEXT(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STORE_DEPTH),
                "element count exceeds depth")
   `ASSERT_IMPL(a_end_only_mode, clock, reset, rsp_valid && rsp_end_of_run,
                rsp_kind == KIND_MODE, "end of run on a non-mode result")
endmodule
